### rtl/cdad_pkg.sv
// cdad_pkg: request and result types, controller/datapath command and status
// types, and the Gregorian month length function
// no dependencies
package cdad_pkg;

  localparam int CMD_W   = 1;
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 16;
  localparam int REM_W   = 7;

  localparam logic [CMD_W-1:0] CMD_ADD = 1'b0;
  localparam logic [CMD_W-1:0] CMD_SUB = 1'b1;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0] DAY_28    = 5'd28;
  localparam logic [DAY_W-1:0] DAY_29    = 5'd29;
  localparam logic [DAY_W-1:0] DAY_30    = 5'd30;
  localparam logic [DAY_W-1:0] DAY_31    = 5'd31;

  // year / 100 as (year * 5243) >> 19, exact for 14-bit years
  localparam int                    DIV100_MUL_W = 13;
  localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;
  localparam int                    DIV100_SHIFT = 19;
  localparam int                    PROD_W       = YEAR_W + DIV100_MUL_W;
  localparam logic [REM_W-1:0]      CENTURY      = 7'd100;
  localparam logic [REM_W-1:0]      REM_LAST     = 7'd99;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [DAY_W-1:0]   start_day;
    logic [MONTH_W-1:0] start_month;
    logic [YEAR_W-1:0]  start_year;
    logic [COUNT_W-1:0] day_count;
  } req_t;

  typedef struct packed {
    logic [DAY_W-1:0]   result_day;
    logic [MONTH_W-1:0] result_month;
    logic [YEAR_W-1:0]  result_year;
    logic               year_out_of_range;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic div;
    logic rem;
    logic norm;
    logic step;
    logic flag_set;
    logic out_load;
  } cdad_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic at_limit;
    logic out_free;
  } cdad_sts_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    len = DAY_31;
    if (m == MONTH_FEB) begin
      len = leap ? DAY_29 : DAY_28;
    end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
      len = DAY_30;
    end
    return len;
  endfunction

endpackage

### rtl/cdad_ctrl.sv
// cdad_ctrl: sequencing state machine for the date stepper
// depends on cdad_pkg
module cdad_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  cdad_pkg::cdad_sts_t sts,
  output cdad_pkg::cdad_cmd_t ctl
);
  import cdad_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_REM  = 3'd2;
  localparam logic [2:0] S_NORM = 3'd3;
  localparam logic [2:0] S_STEP = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          ctl.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        ctl.div    = 1'b1;
        state_next = S_REM;
      end
      S_REM: begin
        ctl.rem    = 1'b1;
        state_next = S_NORM;
      end
      S_NORM: begin
        ctl.norm   = 1'b1;
        state_next = S_STEP;
      end
      S_STEP: begin
        if (sts.count_zero) begin
          state_next = S_FIN;
        end else if (sts.at_limit) begin
          ctl.flag_set = 1'b1;
          state_next   = S_FIN;
        end else begin
          ctl.step = 1'b1;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/cdad_dp.sv
// cdad_dp: date registers, century/remainder leap tracking, day stepper,
// and the result register
// depends on cdad_pkg
module cdad_dp #(
  parameter int unsigned MAX_DAY_COUNT = 65535,
  parameter int unsigned MAX_YEAR      = 9999
) (
  input  logic                clk,
  input  logic                rst,
  input  cdad_pkg::req_t      req,
  input  cdad_pkg::cdad_cmd_t ctl,
  output cdad_pkg::cdad_sts_t sts,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output cdad_pkg::rsp_t      rsp
);
  import cdad_pkg::*;

  localparam int YW = ($clog2(MAX_YEAR + 1) > YEAR_W) ? $clog2(MAX_YEAR + 1) : YEAR_W;
  localparam int QW = YW - 6;
  localparam logic [YW-1:0] YEAR_MAX = YW'(MAX_YEAR);

  logic               sub;
  logic [DAY_W-1:0]   d;
  logic [MONTH_W-1:0] m;
  logic [YW-1:0]      y;
  logic [QW-1:0]      q;
  logic [REM_W-1:0]   r;
  logic [COUNT_W-1:0] n;
  logic               flag;
  logic               out_full;

  logic [PROD_W-1:0]  prod;
  logic [YEAR_W-1:0]  cent;
  logic               leap;
  logic [DAY_W-1:0]   ml;
  logic [DAY_W-1:0]   ml_prev;
  logic [MONTH_W-1:0] m_in;
  logic [DAY_W-1:0]   d_in;
  logic               y_big;
  logic [COUNT_W-1:0] n_in;

  assign prod    = PROD_W'(y[YEAR_W-1:0]) * PROD_W'(DIV100_MUL);
  assign cent    = YEAR_W'(q) * YEAR_W'(CENTURY);
  assign leap    = (r[1:0] == 2'd0) && ((r != '0) || (q[1:0] == 2'd0));
  assign ml      = month_len(m, leap);
  assign ml_prev = month_len(m - 4'd1, leap);

  always_comb begin
    m_in = req.start_month;
    if (req.start_month < MONTH_JAN) begin
      m_in = MONTH_JAN;
    end else if (req.start_month > MONTH_DEC) begin
      m_in = MONTH_DEC;
    end
    d_in  = (req.start_day < DAY_FIRST) ? DAY_FIRST : req.start_day;
    y_big = (32'(req.start_year) > MAX_YEAR);
    n_in  = (32'(req.day_count) > MAX_DAY_COUNT) ? COUNT_W'(MAX_DAY_COUNT) : req.day_count;
  end

  always_comb begin
    sts.count_zero = (n == '0);
    sts.out_free   = !out_full || !rsp_stall;
    if (sub == CMD_SUB) begin
      sts.at_limit = (d == DAY_FIRST) && (m == MONTH_JAN) && (y == '0);
    end else begin
      sts.at_limit = (d >= ml) && (m == MONTH_DEC) && (y == YEAR_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sub  <= req.cmd;
      d    <= d_in;
      m    <= m_in;
      y    <= y_big ? YEAR_MAX : YW'(req.start_year);
      flag <= y_big;
      n    <= n_in;
    end
    if (ctl.div) begin
      q <= QW'(prod[PROD_W-1:DIV100_SHIFT]);
    end
    if (ctl.rem) begin
      r <= REM_W'(y[YEAR_W-1:0] - cent);
    end
    if (ctl.norm && (d > ml)) begin
      d <= ml;
    end
    if (ctl.flag_set) begin
      flag <= 1'b1;
    end
    if (ctl.step) begin
      n <= n - 1'b1;
      if (sub == CMD_ADD) begin
        if (d < ml) begin
          d <= d + 1'b1;
        end else if (m < MONTH_DEC) begin
          d <= DAY_FIRST;
          m <= m + 1'b1;
        end else begin
          d <= DAY_FIRST;
          m <= MONTH_JAN;
          y <= y + 1'b1;
          if (r == REM_LAST) begin
            r <= '0;
            q <= q + 1'b1;
          end else begin
            r <= r + 1'b1;
          end
        end
      end else begin
        if (d > DAY_FIRST) begin
          d <= d - 1'b1;
        end else if (m > MONTH_JAN) begin
          m <= m - 1'b1;
          d <= ml_prev;
        end else begin
          y <= y - 1'b1;
          m <= MONTH_DEC;
          d <= DAY_31;
          if (r == '0) begin
            r <= REM_LAST;
            q <= q - 1'b1;
          end else begin
            r <= r - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      rsp.result_day        <= d;
      rsp.result_month      <= m;
      rsp.result_year       <= y[YEAR_W-1:0];
      rsp.year_out_of_range <= flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (ctl.out_load) begin
      out_full <= 1'b1;
    end else if (!rsp_stall) begin
      out_full <= 1'b0;
    end
  end

  assign rsp_valid = out_full;

endmodule

### rtl/calendar_date_add_days.sv
// calendar_date_add_days: Gregorian date add/subtract, top level
// depends on cdad_pkg, cdad_ctrl, cdad_dp
//
// usage:
//   request channel: req_valid/req_stall with req (cmd, start date, day count).
//   result channel: rsp_valid/rsp_stall with rsp (date and out-of-range flag).
//   a request is taken when req_valid is high and req_stall is low.
//   one request is worked on at a time; req_stall is high from the cycle after
//   acceptance until the result has been moved into the output register.
//   the day stepper advances the date by one day per clock, after the S_DIV,
//   S_REM and S_NORM states have split the year into century and remainder
//   and clamped the day.
//   a run that reaches a year limit stops early and sets year_out_of_range.
//   a new request is taken only once the last result is in the output register.
//   the output register holds a finished result while rsp_stall is high; the
//   next request is taken meanwhile and waits in its final state until the
//   register is free.
//   reset clears the state machine and the output valid; no result is lost
//   or repeated across stalls.
module calendar_date_add_days #(
  parameter int unsigned MAX_DAY_COUNT = 65535,
  parameter int unsigned MAX_YEAR      = 9999
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  cdad_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output cdad_pkg::rsp_t rsp
);
  import cdad_pkg::*;

  cdad_cmd_t ctl;
  cdad_sts_t sts;

  cdad_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  cdad_dp #(
    .MAX_DAY_COUNT (MAX_DAY_COUNT),
    .MAX_YEAR      (MAX_YEAR)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ctl       (ctl),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
